// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that is also checked through reset
`define ASSERT_CLK_NR(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/nirpd_pkg.sv =====
// ---------------------------------------------------------------------------
// nirpd_pkg
// Types, timing windows and gap helpers for the pulse-distance IR decoder.
// ---------------------------------------------------------------------------
package nirpd_pkg;

  // width of the capture counter stamps
  localparam int STAMP_BITS = 16;
  // width of the reload register
  localparam int TOP_W      = 16;
  // width of a gap, including the wrap sum
  localparam int SUM_W      = ((TOP_W > STAMP_BITS) ? TOP_W : STAMP_BITS) + 1;
  // width used for window compares
  localparam int WIN_W      = (SUM_W > 11) ? SUM_W : 11;

  localparam int CODE_W     = 16;
  localparam int FRAME_W    = 32;
  localparam int CNT_W      = 6;
  localparam int IDX_W      = 5;

  localparam logic [TOP_W-1:0]   TOP_RESET = 16'hFFFF;
  localparam logic [CNT_W-1:0]   FRAME_LEN = 6'd32;
  localparam logic [8:0]         BYTE_PAIR = 9'h0FF;

  // timing windows in 100 us ticks
  localparam int WIN_START_LO  = 125;
  localparam int WIN_START_HI  = 140;
  localparam int WIN_ZERO_LO   = 10;
  localparam int WIN_ZERO_HI   = 15;
  localparam int WIN_ONE_LO    = 20;
  localparam int WIN_ONE_HI    = 25;
  localparam int WIN_REP_LO    = 111;
  localparam int WIN_REP_HI    = 115;
  localparam int WIN_PERIOD_LO = 1050;
  localparam int WIN_PERIOD_HI = 1080;

  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [TOP_W-1:0]      top_t;
  typedef logic [CODE_W-1:0]     code_t;

  // measured gap; ok is low when the wrapped difference would be negative
  typedef struct packed {
    logic             ok;
    logic [SUM_W-1:0] value;
  } gap_t;

  // result of one decode step
  typedef struct packed {
    logic  emit;
    logic  repeat_hit;
    code_t code;
  } result_t;

  // gap between two stamps, wrapping at the reload value
  function automatic gap_t gap_of(stamp_t from, stamp_t to, top_t top);
    logic [SUM_W-1:0] f;
    logic [SUM_W-1:0] t;
    logic [SUM_W-1:0] s;
    gap_t             g;
    f = SUM_W'(from);
    t = SUM_W'(to);
    s = SUM_W'(top) + t;
    if (t >= f) begin
      g.ok    = 1'b1;
      g.value = t - f;
    end else if (s >= f) begin
      g.ok    = 1'b1;
      g.value = s - f;
    end else begin
      g.ok    = 1'b0;
      g.value = '0;
    end
    return g;
  endfunction

  // gap lies within lo..hi inclusive
  function automatic logic in_win(gap_t g, int lo, int hi);
    logic [WIN_W-1:0] v;
    v = WIN_W'(g.value);
    return g.ok && (v >= WIN_W'(lo)) && (v <= WIN_W'(hi));
  endfunction

endpackage

// ===== rtl/nirpd_decode.sv =====
// ---------------------------------------------------------------------------
// nirpd_decode
// Frame state and single-pass edge decode: gap windows, bit shift-in,
// byte pair check and repeat handling.
// ---------------------------------------------------------------------------
module nirpd_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  nirpd_pkg::stamp_t   stamp,
  input  nirpd_pkg::top_t     counter_top,
  output nirpd_pkg::result_t  result
);

  // frame state
  nirpd_pkg::stamp_t                   prev_stamp, prev_stamp_next;
  nirpd_pkg::stamp_t                   frame_start, frame_start_next;
  logic [nirpd_pkg::CNT_W-1:0]         bit_count, bit_count_next;
  logic [nirpd_pkg::FRAME_W-1:0]       frame_bits, frame_bits_next;
  logic                                repeat_seen, repeat_seen_next;
  logic                                code_valid, code_valid_next;
  nirpd_pkg::code_t                    held_code, held_code_next;

  nirpd_pkg::gap_t                     edge_gap;
  nirpd_pkg::gap_t                     frame_gap;
  nirpd_pkg::gap_t                     rep_gap;
  logic [7:0]                          b0, b1, b2, b3;
  logic                                check_ok;
  logic                                keep_prev;

  // gap of this edge and span of the prior frame
  assign edge_gap  = nirpd_pkg::gap_of(prev_stamp, stamp, counter_top);
  assign frame_gap = nirpd_pkg::gap_of(frame_start, prev_stamp, counter_top);

  // bytes of the updated frame
  assign b0 = frame_bits_next[7:0];
  assign b1 = frame_bits_next[15:8];
  assign b2 = frame_bits_next[23:16];
  assign b3 = frame_bits_next[31:24];
  assign check_ok = ({1'b0, b0} + {1'b0, b1} == nirpd_pkg::BYTE_PAIR) &&
                    ({1'b0, b2} + {1'b0, b3} == nirpd_pkg::BYTE_PAIR);

  // next state and result for one edge
  always_comb begin
    frame_start_next = frame_start;
    bit_count_next   = bit_count;
    frame_bits_next  = frame_bits;
    repeat_seen_next = repeat_seen;
    code_valid_next  = code_valid;
    held_code_next   = held_code;
    rep_gap          = edge_gap;
    keep_prev        = 1'b0;
    result           = '0;

    // classify the gap
    if (nirpd_pkg::in_win(edge_gap, nirpd_pkg::WIN_START_LO, nirpd_pkg::WIN_START_HI)) begin
      bit_count_next   = '0;
      code_valid_next  = 1'b0;
      frame_bits_next  = '0;
      frame_start_next = prev_stamp;
    end else if (nirpd_pkg::in_win(edge_gap, nirpd_pkg::WIN_ZERO_LO,
                                   nirpd_pkg::WIN_ZERO_HI)) begin
      if (bit_count < nirpd_pkg::FRAME_LEN) begin
        frame_bits_next[bit_count[nirpd_pkg::IDX_W-1:0]] = 1'b0;
        bit_count_next = bit_count + 1'b1;
      end
    end else if (nirpd_pkg::in_win(edge_gap, nirpd_pkg::WIN_ONE_LO,
                                   nirpd_pkg::WIN_ONE_HI)) begin
      if (bit_count < nirpd_pkg::FRAME_LEN) begin
        frame_bits_next[bit_count[nirpd_pkg::IDX_W-1:0]] = 1'b1;
        bit_count_next = bit_count + 1'b1;
      end
    end else if (nirpd_pkg::in_win(edge_gap, nirpd_pkg::WIN_REP_LO,
                                   nirpd_pkg::WIN_REP_HI)) begin
      repeat_seen_next = 1'b1;
      rep_gap          = frame_gap;
      frame_start_next = prev_stamp;
    end

    // full frame check, otherwise pending repeat
    if (bit_count_next >= nirpd_pkg::FRAME_LEN) begin
      if (check_ok) begin
        held_code_next    = {b2, b0};
        code_valid_next   = 1'b1;
        bit_count_next    = '0;
        keep_prev         = 1'b1;
        result.emit       = ({b2, b0} != '0);
        result.repeat_hit = 1'b0;
        result.code       = {b2, b0};
      end
    end else if (repeat_seen_next) begin
      repeat_seen_next = 1'b0;
      if (code_valid_next && nirpd_pkg::in_win(rep_gap, nirpd_pkg::WIN_PERIOD_LO,
                                               nirpd_pkg::WIN_PERIOD_HI)) begin
        keep_prev         = 1'b1;
        result.emit       = 1'b1;
        result.repeat_hit = 1'b1;
        result.code       = held_code_next;
      end
    end

    prev_stamp_next = keep_prev ? prev_stamp : stamp;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_stamp  <= '0;
      frame_start <= '0;
      bit_count   <= '0;
      frame_bits  <= '0;
      repeat_seen <= 1'b0;
      code_valid  <= 1'b0;
      held_code   <= '0;
    end else if (fire) begin
      prev_stamp  <= prev_stamp_next;
      frame_start <= frame_start_next;
      bit_count   <= bit_count_next;
      frame_bits  <= frame_bits_next;
      repeat_seen <= repeat_seen_next;
      code_valid  <= code_valid_next;
      held_code   <= held_code_next;
    end
  end

endmodule

// ===== rtl/nec_ir_pulse_distance_decoder.sv =====
// ---------------------------------------------------------------------------
// nec_ir_pulse_distance_decoder
// Pulse-distance IR remote decoder: one edge stamp per word in, one decoded
// code word out for each nonzero frame that passes the byte pair check, or valid repeat.
// ---------------------------------------------------------------------------
// Path: an accepted stamp goes into the stamp register, and its result word into
// the result register; a stalled result register holds the stamp register.
// Throughput: one stamp per cycle while the result register is not stalled; the
// frame state updates in a single pass between the stamp register and the result register.
// Reset: synchronous, clears frame state and both stage valids and reloads
// counter_top with 65535; no word is accepted while reset is high.
module nec_ir_pulse_distance_decoder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [15:0]           cfg_wr_data,
  input  logic                  capture_valid,
  output logic                  capture_ready,
  input  nirpd_pkg::stamp_t     capture_stamp,
  output logic                  result_valid,
  input  logic                  result_ready,
  output nirpd_pkg::code_t      ir_code,
  output logic                  is_repeat
);

  nirpd_pkg::top_t    counter_top;
  logic               stamp_valid;
  nirpd_pkg::stamp_t  stamp;
  logic               fire;
  nirpd_pkg::result_t result;

  // reload register
  always_ff @(posedge clk) begin
    if (rst) begin
      counter_top <= nirpd_pkg::TOP_RESET;
    end else if (cfg_wr_en) begin
      counter_top <= cfg_wr_data;
    end
  end

  // stamp register advances when the result register can take a word
  assign fire          = stamp_valid && (!result_valid || result_ready);
  assign capture_ready = !rst && (!stamp_valid || fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_valid <= 1'b0;
    end else if (capture_ready) begin
      stamp_valid <= capture_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (capture_valid && capture_ready) begin
      stamp <= capture_stamp;
    end
  end

  // decode step
  nirpd_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .stamp       (stamp),
    .counter_top (counter_top),
    .result      (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && result.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && result.emit) begin
      ir_code   <= result.code;
      is_repeat <= result.repeat_hit;
    end
  end

endmodule

// ===== rtl/nirpd_checker.sv =====
// ---------------------------------------------------------------------------
// nirpd_checker
// Port-level checks for the IR decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nirpd_checker (
  input logic                clk,
  input logic                rst,
  input logic                capture_valid,
  input logic                capture_ready,
  input logic                result_valid,
  input logic                result_ready,
  input nirpd_pkg::code_t    ir_code,
  input logic                is_repeat
);

  // a stalled result word holds
  `ASSERT_CLK(a_result_hold, clk, rst, (result_valid && !result_ready |=> result_valid && $stable(ir_code) && $stable(is_repeat)), "result word changed while stalled")

  // nothing shown right after reset
  `ASSERT_CLK_NR(a_reset_clear, clk, ($past(rst) |-> !result_valid), "result valid after reset")

  // a new result comes from an earlier accepted stamp
  `ASSERT_CLK(a_result_source, clk, rst, ($rose(result_valid) |-> $past(capture_valid && capture_ready, 2)), "result without an accepted stamp")

  // a full frame never delivers a zero code
  `ASSERT_CLK(a_frame_nonzero, clk, rst, (result_valid && !is_repeat |-> ir_code != '0), "zero code from a full frame")

endmodule

bind nec_ir_pulse_distance_decoder nirpd_checker u_nirpd_checker (
  .clk           (clk),
  .rst           (rst),
  .capture_valid (capture_valid),
  .capture_ready (capture_ready),
  .result_valid  (result_valid),
  .result_ready  (result_ready),
  .ir_code       (ir_code),
  .is_repeat     (is_repeat)
);

// ===== dv/tb_nec_ir_pulse_distance_decoder.sv =====
// ---------------------------------------------------------------------------
// tb_nec_ir_pulse_distance_decoder
// Drives edge stamps into the pulse-distance IR decoder and checks every
// decoded word against a cycle-free model of the frame state. A short
// directed run covers the window boundaries and the wrap cases. Random runs
// follow, under several reload values and idling patterns. The random
// stimulus mixes well-formed and broken frames and repeats with random content.
// ---------------------------------------------------------------------------
module tb_nec_ir_pulse_distance_decoder;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 280;
  localparam int NUM_PHASES   = 6;
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    nirpd_pkg::code_t code;
    logic             rep;
  } ir_word_t;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              cfg_wr_en     = 1'b0;
  logic [15:0]       cfg_wr_data   = '0;
  logic              capture_valid = 1'b0;
  logic              capture_ready;
  nirpd_pkg::stamp_t capture_stamp = '0;
  logic              result_valid;
  logic              result_ready  = 1'b0;
  nirpd_pkg::code_t  ir_code;
  logic              is_repeat;

  nec_ir_pulse_distance_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .capture_valid (capture_valid),
    .capture_ready (capture_ready),
    .capture_stamp (capture_stamp),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .ir_code       (ir_code),
    .is_repeat     (is_repeat)
  );

  // stimulus and scoreboard storage
  nirpd_pkg::stamp_t stamp_q[$];
  ir_word_t          due_words[$];
  int       n_sent     = 0;
  int       n_taken    = 0;
  int       n_queued   = 0;
  int       n_errors   = 0;
  int       cycles     = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;

  // model copy of the decoder state
  nirpd_pkg::top_t  top_m    = nirpd_pkg::TOP_RESET;
  int               prev_m   = 0;
  int               start_m  = 0;
  int               nbits_m  = 0;
  logic [31:0]      bits_m   = '0;
  logic             rep_m    = 1'b0;
  logic             valid_m  = 1'b0;
  nirpd_pkg::code_t held_m   = '0;

  // generator cursor, unwrapped, and the reload value it assumes
  int gen_top = 65535;
  int pos     = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report(string msg);
    $display("ERROR @%0d: %s", cycles, msg);
    n_errors++;
  endtask

  // wrapped distance between two stamps, -1 when it would be negative
  function automatic int stamp_distance(int from, int to);
    if (to >= from) return to - from;
    if (int'(top_m) + to >= from) return int'(top_m) + to - from;
    return -1;
  endfunction

  function automatic bit in_range(int v, int lo, int hi);
    return (v >= lo) && (v <= hi);
  endfunction

  // advance the model by one accepted edge stamp
  task automatic decode_edge(nirpd_pkg::stamp_t stamp);
    int       gap;
    int       b0;
    int       b1;
    int       b2;
    int       b3;
    ir_word_t w;
    gap = stamp_distance(prev_m, int'(stamp));
    if (in_range(gap, nirpd_pkg::WIN_START_LO, nirpd_pkg::WIN_START_HI)) begin
      nbits_m = 0;
      valid_m = 1'b0;
      bits_m  = '0;
      start_m = prev_m;
    end else if (in_range(gap, nirpd_pkg::WIN_ZERO_LO, nirpd_pkg::WIN_ZERO_HI)) begin
      if (nbits_m < nirpd_pkg::FRAME_W) begin
        bits_m[nbits_m] = 1'b0;
        nbits_m++;
      end
    end else if (in_range(gap, nirpd_pkg::WIN_ONE_LO, nirpd_pkg::WIN_ONE_HI)) begin
      if (nbits_m < nirpd_pkg::FRAME_W) begin
        bits_m[nbits_m] = 1'b1;
        nbits_m++;
      end
    end else if (in_range(gap, nirpd_pkg::WIN_REP_LO, nirpd_pkg::WIN_REP_HI)) begin
      rep_m   = 1'b1;
      gap     = stamp_distance(start_m, prev_m);
      start_m = prev_m;
    end

    if (nbits_m >= nirpd_pkg::FRAME_W) begin
      b0 = int'(bits_m[7:0]);
      b1 = int'(bits_m[15:8]);
      b2 = int'(bits_m[23:16]);
      b3 = int'(bits_m[31:24]);
      if (b0 + b1 == int'(nirpd_pkg::BYTE_PAIR) &&
          b2 + b3 == int'(nirpd_pkg::BYTE_PAIR)) begin
        held_m  = {bits_m[23:16], bits_m[7:0]};
        valid_m = 1'b1;
        nbits_m = 0;
        if (held_m != '0) begin
          w.code = held_m;
          w.rep  = 1'b0;
          due_words.push_back(w);
        end
        return;
      end
    end else if (rep_m) begin
      rep_m = 1'b0;
      if (valid_m && in_range(gap, nirpd_pkg::WIN_PERIOD_LO, nirpd_pkg::WIN_PERIOD_HI)) begin
        w.code = held_m;
        w.rep  = 1'b1;
        due_words.push_back(w);
        return;
      end
    end
    prev_m = int'(stamp);
  endtask

  // stimulus helpers
  task automatic push_abs(int v);
    pos = v;
    stamp_q.push_back(nirpd_pkg::stamp_t'(v));
    n_queued++;
  endtask

  task automatic step_gap(int g);
    pos = pos + g;
    stamp_q.push_back((gen_top >= 1100) ? nirpd_pkg::stamp_t'(pos % gen_top)
                                        : nirpd_pkg::stamp_t'(pos % 65536));
    n_queued++;
  endtask

  task automatic send_bit(logic b);
    step_gap(b ? $urandom_range(nirpd_pkg::WIN_ONE_LO, nirpd_pkg::WIN_ONE_HI)
               : $urandom_range(nirpd_pkg::WIN_ZERO_LO, nirpd_pkg::WIN_ZERO_HI));
  endtask

  // one random burst: a frame with repeats, a broken or cut frame, or noise
  task automatic gen_burst();
    int          pick;
    int          lead;
    int          n;
    int          i;
    int          k;
    int          ival;
    logic [31:0] bits;
    logic [7:0]  addr;
    logic [7:0]  cmd;
    int          marks[10];
    marks = '{10, 15, 20, 25, 111, 115, 125, 140, 1050, 1080};
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      // full frame, good or with random bits, then a run of repeats
      step_gap($urandom_range(150, 900));
      lead = pos;
      step_gap($urandom_range(nirpd_pkg::WIN_START_LO, nirpd_pkg::WIN_START_HI));
      addr = 8'($urandom);
      cmd  = 8'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        addr = '0;
        cmd  = '0;
      end
      bits = {~cmd, cmd, ~addr, addr};
      if (pick >= 50) bits = $urandom;
      n = (pick >= 50 || $urandom_range(0, 9) == 0) ? 32 + $urandom_range(0, 6) : 32;
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : -1;
      for (i = 0; i < n; i++) begin
        if (i == k) step_gap($urandom_range(0, 200));
        else send_bit(bits[i % 32]);
      end
      for (i = $urandom_range(0, 3); i > 0; i--) begin
        ival = ($urandom_range(0, 4) == 0)
               ? $urandom_range(1040, 1090)
               : $urandom_range(nirpd_pkg::WIN_PERIOD_LO, nirpd_pkg::WIN_PERIOD_HI);
        if (lead + ival > pos) step_gap(lead + ival - pos);
        lead = pos;
        step_gap(($urandom_range(0, 4) == 0)
                 ? $urandom_range(109, 117)
                 : $urandom_range(nirpd_pkg::WIN_REP_LO, nirpd_pkg::WIN_REP_HI));
      end
    end else if (pick < 75) begin
      // frame cut short, maybe followed by a repeat marker
      step_gap($urandom_range(150, 900));
      step_gap($urandom_range(nirpd_pkg::WIN_START_LO, nirpd_pkg::WIN_START_HI));
      n = $urandom_range(0, 31);
      for (i = 0; i < n; i++) send_bit(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 1) == 1)
        step_gap($urandom_range(nirpd_pkg::WIN_REP_LO, nirpd_pkg::WIN_REP_HI));
    end else if (pick < 90) begin
      // gaps around the window boundaries or anywhere
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 1) == 1) step_gap(marks[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1);
        else step_gap($urandom_range(0, 1200));
      end
    end else begin
      // raw stamps over the full range, often past the reload value
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) push_abs($urandom_range(0, 65535));
    end
  endtask

  task automatic wait_drained();
    while (stamp_q.size() != 0 || n_taken != n_sent || due_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_top(int v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 16'(v);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // stamp driver, changes inputs on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      capture_valid <= 1'b0;
    end else if (!(capture_valid && n_taken != n_sent)) begin
      if (stamp_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        capture_stamp <= stamp_q.pop_front();
        capture_valid <= 1'b1;
        n_sent++;
      end else begin
        capture_valid <= 1'b0;
      end
    end
    result_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // monitor: register writes, accepted stamps and decoded words
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("nec_ir_pulse_distance_decoder: mismatch");
      $finish;
    end else if (!rst) begin
      if (cfg_wr_en) top_m = cfg_wr_data;
      if (result_valid && result_ready) begin
        if (due_words.size() == 0) begin
          report($sformatf("word code=%h rep=%b with none expected", ir_code, is_repeat));
        end else begin
          if (ir_code !== due_words[0].code)
            report($sformatf("ir_code got %h want %h", ir_code, due_words[0].code));
          if (is_repeat !== due_words[0].rep)
            report($sformatf("is_repeat got %b want %b", is_repeat, due_words[0].rep));
          void'(due_words.pop_front());
        end
      end
      if (capture_valid && capture_ready) begin
        decode_edge(capture_stamp);
        n_taken++;
      end
    end
  end

  // phase sequencing
  initial begin
    int tops[NUM_PHASES];
    int ph;
    int fill_from;
    int dir_stamps[20];
    int i;
    tops = '{65535, 1, 1100, 45000, 2000, 65535};
    // window edges from a cleared state, then the top of the range and a wrap
    dir_stamps = '{9, 19, 34, 50, 69, 89, 114, 140, 250, 361,
                   476, 592, 716, 841, 981, 1122, 65535, 0, 65534, 5};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 2)
        0: begin
          tx_idle_pct = 10;
          rx_idle_pct = 76;
        end
        1: begin
          tx_idle_pct = 76;
          rx_idle_pct = 10;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      write_top(tops[ph]);
      gen_top = tops[ph];
      if (ph == 0) begin
        for (i = 0; i < 20; i++) push_abs(dir_stamps[i]);
      end
      fill_from = n_queued;
      while (n_queued - fill_from < PHASE_ITEMS) gen_burst();
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_words.size() != 0)
      report($sformatf("%0d decoded words never arrived", due_words.size()));
    if (n_errors == 0)
      $display("nec_ir_pulse_distance_decoder: match");
    else
      $display("nec_ir_pulse_distance_decoder: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/nirpd_pkg.sv
rtl/nirpd_decode.sv
rtl/nec_ir_pulse_distance_decoder.sv
rtl/nirpd_checker.sv
dv/tb_nec_ir_pulse_distance_decoder.sv
